// ----- hw/rtl/spiral_scan_address_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Spiral scan address generator: assertion macros
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_SCAN_ADDRESS_GENERATOR_DEFINES_SVH
`define SPIRAL_SCAN_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is applied
`define SPSAG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SPSAG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPSAG_ASSERT(label, prop, msg)
`define SPSAG_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- hw/rtl/spsag_pkg.sv -----
// ----------------------------------------------------------------------------
// spsag_pkg
// Widths, codes and shared types of the spiral scan address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spsag_pkg;

	localparam int COORD_W   = 8;   // cell row / column field
	localparam int NUM_W     = 17;  // order number field
	localparam int DIM_W     = 9;   // grid dimension register
	localparam int CNT_W     = 2 * DIM_W;  // emitted count, holds rows * cols
	localparam int POS_W     = 12;  // signed walker position
	localparam int LEG_W     = 11;  // leg length / step
	localparam int CFG_IDX_W = 1;

	// request codes
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

	typedef struct packed {
		logic [DIM_W-1:0] rows;   // effective, already clamped
		logic [DIM_W-1:0] cols;
		logic [CNT_W-1:0] total;  // rows * cols
	} grid_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [NUM_W-1:0]   num;
		logic               last;
	} cell_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spsag_if.sv -----
// ----------------------------------------------------------------------------
// spsag channel interfaces
// Valid/ready channels for requests, emitted cells and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface spsag_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [spsag_pkg::COORD_W-1:0]      start_row;
	logic [spsag_pkg::COORD_W-1:0]      start_col;

	modport source (output valid, req_type, start_row, start_col, input ready);
	modport sink   (input valid, req_type, start_row, start_col, output ready);
endinterface

interface spsag_cell_if;
	logic                               valid;
	logic                               ready;
	logic [spsag_pkg::COORD_W-1:0]      cell_row;
	logic [spsag_pkg::COORD_W-1:0]      cell_col;
	logic [spsag_pkg::NUM_W-1:0]        order_number;
	logic                               is_last;

	modport source (output valid, cell_row, cell_col, order_number, is_last, input ready);
	modport sink   (input valid, cell_row, cell_col, order_number, is_last, output ready);
endinterface

interface spsag_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [spsag_pkg::CFG_IDX_W-1:0]    index;
	logic [spsag_pkg::DIM_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spsag_cfg.sv -----
// ----------------------------------------------------------------------------
// spsag_cfg
// Grid dimension registers; clamps written values and keeps rows * cols.
// ----------------------------------------------------------------------------
`default_nettype none

module spsag_cfg #(
	parameter int MAX_DIM = 256
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             wr_en,
	input  wire [spsag_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire [spsag_pkg::DIM_W-1:0]      wr_data,
	output spsag_pkg::grid_t                grid
);
	import spsag_pkg::*;

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [CNT_W-1:0] total_q;
	logic [DIM_W-1:0] eff_data;

	// zero counts as one, anything above MAX_DIM as MAX_DIM
	always_comb begin
		if (wr_data == '0) begin
			eff_data = DIM_W'(1);
		end else if (32'(wr_data) > MAX_DIM) begin
			eff_data = DIM_W'(MAX_DIM);
		end else begin
			eff_data = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(1);
			cols_q  <= DIM_W'(1);
			total_q <= CNT_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_GRID_ROWS: begin
					rows_q  <= eff_data;
					total_q <= CNT_W'(eff_data) * CNT_W'(cols_q);
				end
				CFG_GRID_COLS: begin
					cols_q  <= eff_data;
					total_q <= CNT_W'(rows_q) * CNT_W'(eff_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign grid.rows  = rows_q;
	assign grid.cols  = cols_q;
	assign grid.total = total_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spsag_walker.sv -----
// ----------------------------------------------------------------------------
// spsag_walker
// Spiral walker state and the combinational step: start, move, bounds, count.
// ----------------------------------------------------------------------------
`default_nettype none

module spsag_walker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire spsag_pkg::grid_t           grid,
	input  wire                             cfg_wr,
	input  wire                             fire,
	input  wire                             req_type,
	input  wire [spsag_pkg::COORD_W-1:0]    start_row,
	input  wire [spsag_pkg::COORD_W-1:0]    start_col,
	output logic                            emit,
	output spsag_pkg::cell_t                step_cell,
	output logic                            active
);
	import spsag_pkg::*;

	logic signed [POS_W-1:0] row_q, col_q, row_d, col_d;
	logic [LEG_W-1:0]        leg_len_q, leg_len_d;
	logic [LEG_W-1:0]        leg_step_q, leg_step_d, step_inc;
	logic                    second_q, second_d;
	logic [CNT_W-1:0]        count_q, count_d, count_inc;
	logic                    active_q, active_d;
	logic                    in_grid, last, odd;

	assign step_inc  = leg_step_q + LEG_W'(1);
	assign odd       = leg_len_q[0];

	always_comb begin
		row_d      = row_q;
		col_d      = col_q;
		leg_len_d  = leg_len_q;
		leg_step_d = leg_step_q;
		second_d   = second_q;
		count_d    = count_q;
		active_d   = active_q;
		in_grid    = 1'b0;
		emit       = 1'b0;
		count_inc  = count_q + CNT_W'(1);
		last       = 1'b0;

		if (fire) begin
			if (req_type == REQ_START) begin
				row_d      = POS_W'(start_row);
				col_d      = POS_W'(start_col);
				leg_len_d  = LEG_W'(1);
				leg_step_d = '0;
				second_d   = 1'b0;
				count_inc  = CNT_W'(1);
				in_grid    = (DIM_W'(start_row) < grid.rows) &&
					(DIM_W'(start_col) < grid.cols);
				last       = count_inc >= grid.total;
				emit       = in_grid;
				count_d    = in_grid ? count_inc : '0;
				active_d   = in_grid && !last;
			end else if (active_q) begin
				if (!second_q) begin
					col_d = odd ? col_q + POS_W'(1) : col_q - POS_W'(1);
				end else begin
					row_d = odd ? row_q + POS_W'(1) : row_q - POS_W'(1);
				end
				if (step_inc >= leg_len_q) begin
					leg_step_d = '0;
					second_d   = !second_q;
					if (second_q) begin
						leg_len_d = leg_len_q + LEG_W'(1);
					end
				end else begin
					leg_step_d = step_inc;
				end
				// sign bit clear and below the dimension
				in_grid = !row_d[POS_W-1] && !col_d[POS_W-1] &&
					(row_d < $signed({{(POS_W-DIM_W){1'b0}}, grid.rows})) &&
					(col_d < $signed({{(POS_W-DIM_W){1'b0}}, grid.cols}));
				last    = count_inc >= grid.total;
				emit    = in_grid;
				if (in_grid) begin
					count_d = count_inc;
					if (last) begin
						active_d = 1'b0;
					end
				end
			end
		end

		// a dimension change drops the walk
		if (cfg_wr) begin
			active_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			leg_len_q  <= LEG_W'(1);
			leg_step_q <= '0;
			second_q   <= 1'b0;
			count_q    <= '0;
			active_q   <= 1'b0;
		end else begin
			row_q      <= row_d;
			col_q      <= col_d;
			leg_len_q  <= leg_len_d;
			leg_step_q <= leg_step_d;
			second_q   <= second_d;
			count_q    <= count_d;
			active_q   <= active_d;
		end
	end

	assign step_cell.row  = row_d[COORD_W-1:0];
	assign step_cell.col  = col_d[COORD_W-1:0];
	assign step_cell.num  = count_inc[NUM_W-1:0];
	assign step_cell.last = last;
	assign active         = active_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spiral_scan_address_generator.sv -----
// ----------------------------------------------------------------------------
// spiral_scan_address_generator
// Outward square-spiral cell order of a rows x cols grid from a start cell.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     : write grid_rows (index 0) or grid_cols (index 1) while idle;
//             always ready, a write ends any walk in progress.
//   req_ch  : req_type 0 starts a walk at start_row/start_col, 1 advances
//             the walker one spiral position.
//   cell_ch : one transfer per in-grid position with row, column, running
//             number from 1 and is_last on the final cell.
//   A request passes through one input register, then the walker step
//   into the output register. One request is taken per cycle while cell_ch
//   does not stall; the walker steps combinationally from its registers,
//   so advances stream back to back. Out-of-grid positions produce no transfer.
//   When cell_ch stalls, the output register holds and the input register
//   fills; req_ch.ready drops once both are occupied and cell_ch.ready is low.
//   Reset sets the grid to 1 x 1 and leaves the walker idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spiral_scan_address_generator_defines.svh"

module spiral_scan_address_generator #(
	parameter int MAX_DIM = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	spsag_req_if.sink   req_ch,
	spsag_cell_if.source cell_ch,
	spsag_cfg_if.sink   cfg
);
	import spsag_pkg::*;

	logic               req_valid_s1;
	logic               req_type_s1;
	logic [COORD_W-1:0] start_row_s1;
	logic [COORD_W-1:0] start_col_s1;
	logic               cell_valid_s2;
	cell_t              cell_s2;

	grid_t  grid;
	cell_t  walk_cell;
	logic   walk_emit, walk_active, walk_fire;
	logic   s2_free, s1_adv, cfg_wr;

	assign s2_free   = !cell_valid_s2 || cell_ch.ready;
	assign s1_adv    = !req_valid_s1 || s2_free;
	assign walk_fire = req_valid_s1 && s2_free;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign req_ch.ready = s1_adv;
	assign cfg.ready    = 1'b1;

	spsag_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.grid     (grid)
	);

	spsag_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid      (grid),
		.cfg_wr    (cfg_wr),
		.fire      (walk_fire),
		.req_type  (req_type_s1),
		.start_row (start_row_s1),
		.start_col (start_col_s1),
		.emit      (walk_emit),
		.step_cell (walk_cell),
		.active    (walk_active)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			req_valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && req_ch.valid) begin
			req_type_s1  <= req_ch.req_type;
			start_row_s1 <= req_ch.start_row;
			start_col_s1 <= req_ch.start_col;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			cell_valid_s2 <= walk_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && walk_emit) begin
			cell_s2 <= walk_cell;
		end
	end

	assign cell_ch.valid        = cell_valid_s2;
	assign cell_ch.cell_row     = cell_s2.row;
	assign cell_ch.cell_col     = cell_s2.col;
	assign cell_ch.order_number = cell_s2.num;
	assign cell_ch.is_last      = cell_s2.last;

	// final cell of the grid closes the walk
	`SPSAG_ASSERT(a_last_ends_walk, (walk_emit && walk_cell.last) |=> !walk_active, "walker still active after final cell")
	// an in-grid start is always numbered one
	`SPSAG_ASSERT(a_start_is_one, (walk_emit && req_type_s1 == REQ_START) |=> (cell_ch.valid && cell_ch.order_number == NUM_W'(1)), "start cell not numbered one")
	// an advance on an idle walker produces nothing
	`SPSAG_ASSERT(a_idle_advance_silent, (walk_fire && req_type_s1 == REQ_ADVANCE && !walk_active) |=> !cell_ch.valid, "cell emitted by an idle walker")
	// no cell is pending straight out of reset
	`SPSAG_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!cell_ch.valid && !walk_active), "state not cleared by reset")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: spiral scan address generator
// Drives start/advance requests and grid writes with random gaps and stalls,
// tracks the spiral walk in a local model and checks every emitted cell.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spsag_pkg::*;

	typedef enum logic [1:0] {W_MODEL, W_NONE, W_CELL} want_t;
	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             op;     // request code or register index
		logic [7:0]       r;
		logic [DIM_W-1:0] c;      // start column, or register data
		want_t            want;
		cell_t            exp_cell;
	} script_row_t;

	localparam cell_t NO_CELL  = '0;
	localparam int    SCRIPT_N = 32;
	localparam int    SETTLE   = 6;
	localparam int    RAND_N   = 2000;

	logic clk = 1'b0;
	logic arst_n;

	spsag_req_if  req_bus ();
	spsag_cell_if cell_bus ();
	spsag_cfg_if  cfg_bus ();

	spiral_scan_address_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_bus),
		.cell_ch(cell_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// local copy of the walker
	logic [DIM_W-1:0]   grid_rows_q;
	logic [DIM_W-1:0]   grid_cols_q;
	logic signed [11:0] walk_r;
	logic signed [11:0] walk_c;
	logic [10:0]        leg_len;
	logic [10:0]        leg_pos;
	logic               leg_turn;
	logic [17:0]        cells_out;
	logic               walk_on;

	cell_t pending_cells[$];
	int    bad_count = 0;
	int    fed = 0;
	bit    rush = 1'b0;
	bit    calm_src = 1'b0;
	bit    calm_snk = 1'b0;

	script_row_t script [SCRIPT_N] = '{
		'{ROW_REQ, REQ_START,   8'd0,   9'd0,   W_CELL,  '{8'd0, 8'd0, 17'd1, 1'b1}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_START,   8'd255, 9'd255, W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_ROWS, 8'd0, 9'd0,   W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_COLS, 8'd0, 9'd511, W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_START,   8'd0,   9'd255, W_CELL,  '{8'd0, 8'd255, 17'd1, 1'b0}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_START,   8'd0,   9'd128, W_CELL,  '{8'd0, 8'd128, 17'd1, 1'b0}},
		'{ROW_CFG, CFG_GRID_ROWS, 8'd0, 9'd256, W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_COLS, 8'd0, 9'd256, W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_START,   8'd255, 9'd255, W_CELL,  '{8'd255, 8'd255, 17'd1, 1'b0}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_MODEL, NO_CELL},
		'{ROW_CFG, CFG_GRID_ROWS, 8'd0, 9'd257, W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_COLS, 8'd0, 9'd1,   W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_START,   8'd255, 9'd0,   W_CELL,  '{8'd255, 8'd0, 17'd1, 1'b0}},
		'{ROW_REQ, REQ_START,   8'd128, 9'd1,   W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_ROWS, 8'd0, 9'd2,   W_NONE,  NO_CELL},
		'{ROW_CFG, CFG_GRID_COLS, 8'd0, 9'd2,   W_NONE,  NO_CELL},
		'{ROW_REQ, REQ_START,   8'd0,   9'd0,   W_CELL,  '{8'd0, 8'd0, 17'd1, 1'b0}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_CELL,  '{8'd0, 8'd1, 17'd2, 1'b0}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_CELL,  '{8'd1, 8'd1, 17'd3, 1'b0}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_CELL,  '{8'd1, 8'd0, 17'd4, 1'b1}},
		'{ROW_REQ, REQ_ADVANCE, 8'd0,   9'd0,   W_NONE,  NO_CELL}
	};

	function automatic int clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 9'd256)
			return 256;
		return int'(v);
	endfunction

	function automatic bit on_grid(input logic signed [11:0] r, input logic signed [11:0] c);
		return r >= 0 && c >= 0 && int'(r) < clamp_dim(grid_rows_q)
			&& int'(c) < clamp_dim(grid_cols_q);
	endfunction

	function automatic void take_cell(output cell_t got);
		cells_out = cells_out + 18'd1;
		got.row  = walk_r[7:0];
		got.col  = walk_c[7:0];
		got.num  = cells_out[16:0];
		got.last = int'(cells_out) >= clamp_dim(grid_rows_q) * clamp_dim(grid_cols_q);
		if (got.last)
			walk_on = 1'b0;
	endfunction

	// one request into the walker; returns 1 when it yields a cell
	function automatic bit spiral_next(input logic kind, input logic [7:0] r,
			input logic [7:0] c, output cell_t got);
		got = NO_CELL;
		if (kind == REQ_START) begin
			walk_r    = $signed({4'd0, r});
			walk_c    = $signed({4'd0, c});
			leg_len   = 11'd1;
			leg_pos   = 11'd0;
			leg_turn  = 1'b0;
			cells_out = 18'd0;
			walk_on   = on_grid(walk_r, walk_c);
			if (!walk_on)
				return 1'b0;
			take_cell(got);
			return 1'b1;
		end
		if (!walk_on)
			return 1'b0;
		// odd legs go right then down, even legs left then up
		if (!leg_turn)
			walk_c = leg_len[0] ? walk_c + 12'sd1 : walk_c - 12'sd1;
		else
			walk_r = leg_len[0] ? walk_r + 12'sd1 : walk_r - 12'sd1;
		leg_pos = leg_pos + 11'd1;
		if (leg_pos >= leg_len) begin
			leg_pos = 11'd0;
			if (leg_turn)
				leg_len = leg_len + 11'd1;
			leg_turn = !leg_turn;
		end
		if (!on_grid(walk_r, walk_c))
			return 1'b0;
		take_cell(got);
		return 1'b1;
	endfunction

	function automatic void log_fault(input string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return DIM_W'($urandom_range(257, 511));
		if (roll == 2)
			return 9'd256;
		if (roll <= 5)
			return DIM_W'($urandom_range(9, 40));
		return DIM_W'($urandom_range(1, 8));
	endfunction

	task automatic send_req(input logic kind, input logic [7:0] r, input logic [7:0] c,
			input want_t want, input cell_t typed);
		int    gap;
		cell_t guess;
		bit    hit;
		gap = (rush || calm_src) ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 63) == 0)
			calm_src = !calm_src;
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.req_type  <= kind;
		req_bus.start_row <= r;
		req_bus.start_col <= c;
		do @(posedge clk); while (!req_bus.ready);
		hit = spiral_next(kind, r, c, guess);
		case (want)
			W_MODEL: begin
				if (hit)
					pending_cells.push_back(guess);
			end
			W_CELL: pending_cells.push_back(typed);
			default: ;
		endcase
	endtask

	task automatic feed(input logic kind, input logic [7:0] r, input logic [7:0] c);
		// advances into an idle walker do not count
		if (kind == REQ_START || walk_on)
			fed++;
		send_req(kind, r, c, W_MODEL, NO_CELL);
	endtask

	task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val,
			input bit keep);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		if (!keep)
			cfg_bus.valid <= 1'b0;
		if (idx == CFG_GRID_ROWS)
			grid_rows_q = val;
		else
			grid_cols_q = val;
		walk_on = 1'b0;
	endtask

	// drain outstanding cells, then cover an advance still in the pipe
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int rows_eff;
		int cols_eff;
		int cap;
		int steps;
		bit w_rows;
		bit w_cols;

		arst_n            <= 1'b0;
		req_bus.valid     <= 1'b0;
		req_bus.req_type  <= REQ_START;
		req_bus.start_row <= '0;
		req_bus.start_col <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.index     <= CFG_GRID_ROWS;
		cfg_bus.data      <= '0;
		grid_rows_q = 9'd1;
		grid_cols_q = 9'd1;
		walk_r      = '0;
		walk_c      = '0;
		leg_len     = 11'd1;
		leg_pos     = '0;
		leg_turn    = 1'b0;
		cells_out   = '0;
		walk_on     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				write_grid(script[i].op, script[i].c, 1'b0);
			end else begin
				send_req(script[i].op, script[i].r, script[i].c[7:0], script[i].want,
					script[i].exp_cell);
			end
		end

		// full 12 x 12 sweep from near the middle, back to back, up to the last cell
		settle();
		rush = 1'b1;
		write_grid(CFG_GRID_ROWS, 9'd12, 1'b1);
		write_grid(CFG_GRID_COLS, 9'd12, 1'b0);
		send_req(REQ_START, 8'd5, 8'd6, W_MODEL, NO_CELL);
		while (walk_on)
			send_req(REQ_ADVANCE, 8'($urandom), 8'($urandom), W_MODEL, NO_CELL);
		settle();
		rush = 1'b0;

		while (fed < RAND_N) begin
			settle();
			w_rows = $urandom_range(0, 3) != 0;
			w_cols = $urandom_range(0, 3) != 0;
			if (w_rows)
				write_grid(CFG_GRID_ROWS, pick_dim(), w_cols);
			if (w_cols)
				write_grid(CFG_GRID_COLS, pick_dim(), 1'b0);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					feed(REQ_ADVANCE, 8'($urandom), 8'($urandom));
			repeat ($urandom_range(1, 4)) begin
				rows_eff = clamp_dim(grid_rows_q);
				cols_eff = clamp_dim(grid_cols_q);
				if ($urandom_range(0, 4) == 0)
					feed(REQ_START, 8'($urandom), 8'($urandom));
				else
					feed(REQ_START, 8'($urandom_range(0, rows_eff - 1)),
						8'($urandom_range(0, cols_eff - 1)));
				cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : 600;
				steps = 0;
				while (walk_on && steps < cap) begin
					feed(REQ_ADVANCE, 8'($urandom), 8'($urandom));
					steps++;
				end
				// stray requests: restarts mid walk, advances after the end
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3))
						feed($urandom_range(0, 1) ? REQ_ADVANCE : REQ_START,
							8'($urandom), 8'($urandom));
			end
		end

		settle();
		if (bad_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin : cell_sink
		int    stall;
		cell_t seen;
		cell_t want;
		cell_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = (rush || calm_snk) ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 63) == 0)
				calm_snk = !calm_snk;
			if (stall != 0) begin
				cell_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cell_bus.ready <= 1'b1;
			do @(posedge clk); while (!cell_bus.valid);
			seen = '{cell_bus.cell_row, cell_bus.cell_col, cell_bus.order_number,
				cell_bus.is_last};
			if (pending_cells.size() == 0) begin
				log_fault($sformatf("unexpected cell: row %0d col %0d num %0d last %0d",
					seen.row, seen.col, seen.num, seen.last));
			end else begin
				want = pending_cells.pop_front();
				if (seen.row !== want.row || seen.col !== want.col
						|| seen.num !== want.num || seen.last !== want.last)
					log_fault($sformatf({"cell mismatch: expected row %0d col %0d num %0d",
						" last %0d, got row %0d col %0d num %0d last %0d"},
						want.row, want.col, want.num, want.last,
						seen.row, seen.col, seen.num, seen.last));
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
